@@ rtl/core/itr_pkg.sv @@
// Shared constants, types and helpers for the integer to radix text converter.
`default_nettype none
package itr_pkg;

	localparam int VALUE_BITS  = 64;
	localparam int MAX_DIGITS  = 64;
	localparam int DIGIT_LIMIT = 64;
	localparam int ADDR_W      = $clog2(MAX_DIGITS);
	localparam int BITCNT_W    = $clog2(VALUE_BITS);
	localparam int DIGIT_W     = 6;
	localparam int LEN_W       = 7;

	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [DIGIT_W-1:0] digit_t;

	localparam len_t   MAX_LEN     = LEN_W'(MAX_DIGITS);
	localparam len_t   LIMIT_LEN   = LEN_W'(DIGIT_LIMIT);
	localparam digit_t RADIX_MIN   = 6'd2;
	localparam digit_t RADIX_MAX   = 6'd36;
	localparam digit_t RADIX_RESET = 6'd10;
	localparam logic [7:0] CHAR_ZERO   = 8'd48;
	localparam logic [7:0] LOWER_OFFS  = 8'd87;
	localparam logic [7:0] UPPER_OFFS  = 8'd55;
	localparam digit_t     DEC_MAX     = 6'd9;

	typedef enum logic [1:0] {
		REG_RADIX = 2'd0,
		REG_UPPER = 2'd1,
		REG_PAD   = 2'd2
	} reg_index_t;

	function automatic logic [7:0] digit_char(input digit_t d, input logic upper);
		logic [7:0] offs;
		begin
			offs = upper ? UPPER_OFFS : LOWER_OFFS;
			if (d > DEC_MAX) begin
				digit_char = {2'b00, d} + offs;
			end else begin
				digit_char = {2'b00, d} + CHAR_ZERO;
			end
		end
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/integer_to_radix_text.sv @@
// Top level: unsigned integer to ASCII text in a configurable base.
//
// Usage: the input channel (in_valid / in_stall) takes one number per
// transfer; in_stall stays high from that transfer until the last character
// of the conversion has been taken. The output channel (out_valid /
// out_stall) gives one character per transfer, most significant first, with
// last set on the final one. A base outside 2..36 gives a single result with
// character 0, last 1 and bad_radix 1, offered the cycle after the transfer.
// Configuration writes (cfg_valid / cfg_ready) are taken every cycle out of
// reset; write them only while no conversion is in flight. Unknown indexes
// are dropped.
// Operation: each digit is produced by one bit-serial restoring divider, one
// quotient bit per cycle. Each output character then passes through a memory
// read, a load and a transfer; the transfer waits while the receiver stalls.
// Reset: arst_n clears the sequencer, the output valid and sets radix 10,
// lower case, minimal width; in_stall is high and cfg_ready low meanwhile.
// A stalled result holds until taken.
`default_nettype none
module integer_to_radix_text
	import itr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [63:0] number,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [7:0]  character,
	output      logic        last,
	output      logic        bad_radix,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [6:0]  cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DIV  = 7'b0000010,
		S_NEXT = 7'b0000100,
		S_LEN  = 7'b0001000,
		S_READ = 7'b0010000,
		S_LOAD = 7'b0100000,
		S_SEND = 7'b1000000
	} state_t;

	state_t                 state_q;
	digit_t                 radix_q;
	logic                   upper_q;
	len_t                   pad_q;
	logic [VALUE_BITS-1:0]  value_q;
	digit_t                 rem_q;
	logic [BITCNT_W-1:0]    bitcnt_q;
	len_t                   ndig_q;
	len_t                   len_q;
	len_t                   k_q;
	logic                   fill_q;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;
	logic                   bad_q;

	logic                   in_xfer;
	logic                   radix_bad;
	logic [DIGIT_W:0]       trial;
	logic                   qbit;
	digit_t                 rem_next;
	len_t                   pos;
	len_t                   len_min;
	logic                   ram_we;
	logic                   ram_re;
	digit_t                 ram_rdata;

	// Configuration port never pushes back once out of reset.
	assign cfg_ready = arst_n;

	assign in_stall  = !arst_n || (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign radix_bad = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);

	// One restoring division step: bring in the next dividend bit, subtract
	// the base when it fits.
	assign trial    = {rem_q, value_q[VALUE_BITS-1]};
	assign qbit     = (trial >= {1'b0, radix_q});
	assign rem_next = qbit ? DIGIT_W'(trial - {1'b0, radix_q}) : trial[DIGIT_W-1:0];

	// Digit position in the stored string for the character now being read.
	assign pos     = len_q - len_t'(1) - k_q;
	assign len_min = (pad_q == '0) ? ndig_q : pad_q;

	// The last division step writes the remainder as the next digit; only
	// the lowest MAX_DIGITS digits are ever shown, so keep just those.
	assign ram_we = (state_q == S_DIV) && (bitcnt_q == '0) && (ndig_q < MAX_LEN);
	assign ram_re = (state_q == S_READ);

	itr_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ndig_q[ADDR_W-1:0]),
		.wdata (rem_next),
		.re    (ram_re),
		.raddr (pos[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			upper_q <= 1'b0;
			pad_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIX: radix_q <= cfg_data[DIGIT_W-1:0];
				REG_UPPER: upper_q <= cfg_data[0];
				REG_PAD:   pad_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			bitcnt_q    <= '0;
			ndig_q      <= '0;
			len_q       <= '0;
			k_q         <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						bitcnt_q <= BITCNT_W'(VALUE_BITS - 1);
						ndig_q   <= '0;
						if (radix_bad) begin
							// Error result goes straight to the output register.
							out_valid_q <= 1'b1;
							state_q     <= S_SEND;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					bitcnt_q <= bitcnt_q - BITCNT_W'(1);
					if (bitcnt_q == '0) begin
						ndig_q  <= ndig_q + len_t'(1);
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					// Keep dividing while the quotient is nonzero and under DIGIT_LIMIT digits are made.
					if ((value_q != '0) && (ndig_q < LIMIT_LEN)) begin
						bitcnt_q <= BITCNT_W'(VALUE_BITS - 1);
						state_q  <= S_DIV;
					end else begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					len_q   <= (len_min > MAX_LEN) ? MAX_LEN : len_min;
					k_q     <= '0;
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_SEND;
				end
				S_SEND: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + len_t'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: dividend/quotient, remainder, fill flag and output payload.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			value_q <= number[VALUE_BITS-1:0];
			rem_q   <= '0;
			char_q  <= '0;
			last_q  <= 1'b1;
			bad_q   <= radix_bad;
		end
		if (state_q == S_DIV) begin
			value_q <= {value_q[VALUE_BITS-2:0], qbit};
			rem_q   <= (bitcnt_q == '0) ? '0 : rem_next;
		end
		if (state_q == S_READ) begin
			fill_q <= !(pos < ndig_q);
		end
		if (state_q == S_LOAD) begin
			char_q <= fill_q ? CHAR_ZERO : digit_char(ram_rdata, upper_q);
			last_q <= (k_q == (len_q - len_t'(1)));
			bad_q  <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;
	assign bad_radix = bad_q;

endmodule
`default_nettype wire

@@ rtl/core/itr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module itr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire
